// File: hw/rtl/rgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared constants and types of the radial gradient pixel unit.
// ----------------------------------------------------------------------------
package rgp_pkg;

   localparam int COORD_BITS_DEFAULT    = 15;
   localparam int SUBPIXEL_BITS_DEFAULT = 4;
   localparam int CHANNEL_BITS_DEFAULT  = 8;

   // blend factor fraction bits; 1 << FRAC_BITS means one
   localparam int FRAC_BITS = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INNER_RADIUS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTER_RADIUS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_COLOR  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_COLOR    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_OUTSIDE = 3'd6;

   localparam int RST_CENTER_X     = 400;
   localparam int RST_CENTER_Y     = 400;
   localparam int RST_INNER_RADIUS = 0;
   localparam int RST_OUTER_RADIUS = 400;
   localparam int RST_END_COLOR    = 255;

   // how the blend factor is chosen for a word
   localparam logic [1:0] VM_ZERO = 2'd0;
   localparam logic [1:0] VM_ONE  = 2'd1;
   localparam logic [1:0] VM_FRAC = 2'd2;

   typedef struct packed {
      logic       valid;
      logic       blank;
      logic [1:0] v_mode;
   } tag_type;

endpackage

// File: hw/rtl/rgp_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_sqrt_cell
// One digit of a pipelined integer square root: takes two radicand bits,
// makes one root bit and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module rgp_sqrt_cell
   import rgp_pkg::*;
#(
   parameter int R_BITS = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  tag_type             tag_in,
   input  logic [2*R_BITS-1:0] rad_in,
   input  logic [R_BITS+1:0]   rem_in,
   input  logic [R_BITS-1:0]   root_in,
   output tag_type             tag_out,
   output logic [2*R_BITS-1:0] rad_out,
   output logic [R_BITS+1:0]   rem_out,
   output logic [R_BITS-1:0]   root_out
);

   tag_type             tag_ff;
   logic [2*R_BITS-1:0] rad_ff, rad_in_next;
   logic [R_BITS+1:0]   rem_ff, rem_in_next;
   logic [R_BITS-1:0]   root_ff, root_in_next;
   logic [R_BITS+1:0]   rem_sh, trial;

   always_comb begin
      rem_sh = {rem_in[R_BITS-1:0], rad_in[2*R_BITS-1 -: 2]};
      trial  = {root_in, 2'b01};
      rad_in_next = {rad_in[2*R_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in_next  = rem_sh - trial;
         root_in_next = {root_in[R_BITS-2:0], 1'b1};
      end else begin
         rem_in_next  = rem_sh;
         root_in_next = {root_in[R_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff  <= rad_in_next;
         rem_ff  <= rem_in_next;
         root_ff <= root_in_next;
      end
   end

   assign tag_out  = tag_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

// File: hw/rtl/rgp_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_div_cell
// One step of a pipelined restoring divider: one quotient bit per cell.
// ----------------------------------------------------------------------------
module rgp_div_cell
   import rgp_pkg::*;
#(
   parameter int W_BITS = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [W_BITS-1:0]    span,
   input  tag_type              tag_in,
   input  logic [W_BITS-1:0]    rem_in,
   input  logic [FRAC_BITS-1:0] quo_in,
   output tag_type              tag_out,
   output logic [W_BITS-1:0]    rem_out,
   output logic [FRAC_BITS-1:0] quo_out
);

   tag_type              tag_ff;
   logic [W_BITS-1:0]    rem_ff, rem_in_next, rem_sh;
   logic [FRAC_BITS-1:0] quo_ff, quo_in_next;

   always_comb begin
      rem_sh = {rem_in[W_BITS-2:0], 1'b0};
      if (rem_sh >= span) begin
         rem_in_next = rem_sh - span;
         quo_in_next = {quo_in[FRAC_BITS-2:0], 1'b1};
      end else begin
         rem_in_next = rem_sh;
         quo_in_next = {quo_in[FRAC_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in_next;
         quo_ff <= quo_in_next;
      end
   end

   assign tag_out = tag_ff;
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule

// File: hw/rtl/radial_gradient_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_gradient_pixel_unit
// Returns the RGBA colour of a radial gradient for each pixel coordinate.
// ----------------------------------------------------------------------------
// Usage: write the gradient registers over the csr_ port (always ready) while
// no word is in flight, then send one pixel coordinate per req_ word. Each
// accepted word gives exactly one rsp_ word carrying red, green, blue, alpha.
// Throughput: one word per cycle unless rsp_stall holds a waiting word. The
// pipeline runs from acceptance to rsp_valid through the distance arithmetic
// (stages a, b and c), one square-root cell per root bit, one subtract, one
// divider cell per fraction bit (16) and one blend stage into the output
// register.
// When rsp_stall holds a waiting word the whole cell chain freezes and
// req_stall rises in the same cycle; nothing is lost or dropped.
// Reset empties the pipeline and restores the register defaults: centre
// (400, 400), radii 0 and 400, white to opaque black, clipping off.
// ----------------------------------------------------------------------------
module radial_gradient_pixel_unit
   import rgp_pkg::*;
#(
   parameter int COORD_BITS    = COORD_BITS_DEFAULT,
   parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEFAULT,
   parameter int CHANNEL_BITS  = CHANNEL_BITS_DEFAULT,
   localparam int POS_BITS   = COORD_BITS + SUBPIXEL_BITS - 1,
   localparam int COLOR_BITS = 4 * CHANNEL_BITS,
   localparam int CSR_BITS   = (COLOR_BITS > POS_BITS) ? COLOR_BITS : POS_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_pixel_x,
   input  logic signed [COORD_BITS-1:0]  req_pixel_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CHANNEL_BITS-1:0]       rsp_red,
   output logic [CHANNEL_BITS-1:0]       rsp_green,
   output logic [CHANNEL_BITS-1:0]       rsp_blue,
   output logic [CHANNEL_BITS-1:0]       rsp_alpha,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_BITS-1:0]           csr_data
);

   localparam int D_BITS  = POS_BITS + 1;   // |offset|
   localparam int SQ_BITS = 2 * D_BITS + 1; // squared distance
   localparam int R_BITS  = D_BITS + 1;     // root bits
   localparam int W_BITS  = POS_BITS + 1;   // divider remainder
   localparam int V_BITS  = FRAC_BITS + 1;
   localparam logic [V_BITS-1:0] V_ONE = V_BITS'(1) << FRAC_BITS;
   localparam logic [CHANNEL_BITS+V_BITS:0] ROUND_HALF =
      (CHANNEL_BITS+V_BITS+1)'(1) << (FRAC_BITS - 1);

   // configuration registers
   logic [POS_BITS-1:0]   center_x_ff, center_y_ff, inner_ff, outer_ff;
   logic [COLOR_BITS-1:0] start_color_ff, end_color_ff;
   logic                  clip_ff;
   logic [2*POS_BITS-1:0] r0sq_ff, r1sq_ff;
   logic [W_BITS-1:0]     span;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= POS_BITS'(RST_CENTER_X);
         center_y_ff    <= POS_BITS'(RST_CENTER_Y);
         inner_ff       <= POS_BITS'(RST_INNER_RADIUS);
         outer_ff       <= POS_BITS'(RST_OUTER_RADIUS);
         start_color_ff <= '1;
         end_color_ff   <= COLOR_BITS'(RST_END_COLOR);
         clip_ff        <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CENTER_X:     center_x_ff    <= csr_data[POS_BITS-1:0];
            CSR_CENTER_Y:     center_y_ff    <= csr_data[POS_BITS-1:0];
            CSR_INNER_RADIUS: inner_ff       <= csr_data[POS_BITS-1:0];
            CSR_OUTER_RADIUS: outer_ff       <= csr_data[POS_BITS-1:0];
            CSR_START_COLOR:  start_color_ff <= csr_data[COLOR_BITS-1:0];
            CSR_END_COLOR:    end_color_ff   <= csr_data[COLOR_BITS-1:0];
            CSR_CLIP_OUTSIDE: clip_ff        <= csr_data[0];
            default: ;
         endcase
      end
   end

   // radius squares settle long before a word reaches the compare
   always_ff @(posedge clock) begin
      r0sq_ff <= inner_ff * inner_ff;
      r1sq_ff <= outer_ff * outer_ff;
   end

   assign span = W_BITS'(outer_ff - inner_ff);

   // freeze the whole pipeline while a finished word is held
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // stage a: offsets from the centre
   logic signed [POS_BITS+1:0] px_s, py_s, dx_s, dy_s;
   logic [D_BITS-1:0]  dx_ff, dy_ff;
   logic               a_valid_ff, b_valid_ff, c_valid_ff;

   always_comb begin
      px_s = (POS_BITS+2)'(req_pixel_x) <<< SUBPIXEL_BITS;
      py_s = (POS_BITS+2)'(req_pixel_y) <<< SUBPIXEL_BITS;
      dx_s = px_s - signed'({2'b00, center_x_ff});
      dy_s = py_s - signed'({2'b00, center_y_ff});
   end

   // stages b and c: squares, then sum
   logic [2*D_BITS-1:0] dxsq_ff, dysq_ff;
   logic [SQ_BITS-1:0]  sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff   <= dx_s[POS_BITS+1] ? D_BITS'(-dx_s) : D_BITS'(dx_s);
         dy_ff   <= dy_s[POS_BITS+1] ? D_BITS'(-dy_s) : D_BITS'(dy_s);
         dxsq_ff <= dx_ff * dx_ff;
         dysq_ff <= dy_ff * dy_ff;
         sq_ff   <= SQ_BITS'(dxsq_ff) + SQ_BITS'(dysq_ff);
      end
   end

   // ring classification, fed into the root chain
   tag_type c_tag;
   logic    below_in, above_out, at_or_in, at_or_out;

   always_comb begin
      below_in  = SQ_BITS'(sq_ff) <  SQ_BITS'(r0sq_ff);
      at_or_in  = SQ_BITS'(sq_ff) <= SQ_BITS'(r0sq_ff);
      above_out = SQ_BITS'(sq_ff) >  SQ_BITS'(r1sq_ff);
      at_or_out = SQ_BITS'(sq_ff) >= SQ_BITS'(r1sq_ff);
      c_tag.valid = c_valid_ff;
      c_tag.blank = (inner_ff == outer_ff) || (clip_ff && (below_in || above_out));
      if (at_or_in) begin
         c_tag.v_mode = VM_ZERO;
      end else if (at_or_out) begin
         c_tag.v_mode = VM_ONE;
      end else begin
         c_tag.v_mode = VM_FRAC;
      end
   end

   tag_type             s_tag  [R_BITS+1];
   logic [2*R_BITS-1:0] s_rad  [R_BITS+1];
   logic [R_BITS+1:0]   s_rem  [R_BITS+1];
   logic [R_BITS-1:0]   s_root [R_BITS+1];

   assign s_tag[0]  = c_tag;
   assign s_rad[0]  = (2*R_BITS)'(sq_ff);
   assign s_rem[0]  = '0;
   assign s_root[0] = '0;

   for (genvar i = 0; i < R_BITS; i++) begin : g_sqrt
      rgp_sqrt_cell #(.R_BITS(R_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .tag_in   (s_tag[i]),
         .rad_in   (s_rad[i]),
         .rem_in   (s_rem[i]),
         .root_in  (s_root[i]),
         .tag_out  (s_tag[i+1]),
         .rad_out  (s_rad[i+1]),
         .rem_out  (s_rem[i+1]),
         .root_out (s_root[i+1])
      );
   end

   // distance beyond the inner circle: below span when the mode is fractional
   tag_type           n_tag_ff;
   logic [W_BITS-1:0] n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_tag_ff <= '0;
      end else if (advance) begin
         n_tag_ff <= s_tag[R_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff <= W_BITS'(s_root[R_BITS] - R_BITS'(inner_ff));
      end
   end

   tag_type              q_tag [FRAC_BITS+1];
   logic [W_BITS-1:0]    q_rem [FRAC_BITS+1];
   logic [FRAC_BITS-1:0] q_quo [FRAC_BITS+1];

   assign q_tag[0] = n_tag_ff;
   assign q_rem[0] = n_ff;
   assign q_quo[0] = '0;

   for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
      rgp_div_cell #(.W_BITS(W_BITS)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .span    (span),
         .tag_in  (q_tag[j]),
         .rem_in  (q_rem[j]),
         .quo_in  (q_quo[j]),
         .tag_out (q_tag[j+1]),
         .rem_out (q_rem[j+1]),
         .quo_out (q_quo[j+1])
      );
   end

   // blend into the output register
   tag_type            f_tag;
   logic [V_BITS-1:0]  v, v_inv;
   logic [CHANNEL_BITS-1:0] ch_in [4];
   logic [CHANNEL_BITS-1:0] ch_ff [4];

   assign f_tag = q_tag[FRAC_BITS];

   always_comb begin
      case (f_tag.v_mode)
         VM_ZERO: v = '0;
         VM_ONE:  v = V_ONE;
         VM_FRAC: v = V_BITS'(q_quo[FRAC_BITS]);
         default: v = '0;
      endcase
      v_inv = V_ONE - v;
   end

   for (genvar k = 0; k < 4; k++) begin : g_blend
      logic [CHANNEL_BITS-1:0]   s_ch, e_ch;
      logic [CHANNEL_BITS+V_BITS:0] mix;
      always_comb begin
         s_ch = start_color_ff[(3-k)*CHANNEL_BITS +: CHANNEL_BITS];
         e_ch = end_color_ff[(3-k)*CHANNEL_BITS +: CHANNEL_BITS];
         mix  = (CHANNEL_BITS+V_BITS+1)'(s_ch * v_inv)
              + (CHANNEL_BITS+V_BITS+1)'(e_ch * v) + ROUND_HALF;
         ch_in[k] = f_tag.blank ? '0 : mix[FRAC_BITS +: CHANNEL_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= f_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 4; k++) begin
            ch_ff[k] <= ch_in[k];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = ch_ff[0];
   assign rsp_green = ch_ff[1];
   assign rsp_blue  = ch_ff[2];
   assign rsp_alpha = ch_ff[3];

   a_equal_radii_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (inner_ff == outer_ff) |->
         rsp_red == '0 && rsp_green == '0 && rsp_blue == '0 && rsp_alpha == '0)
      else $error("equal radii gave a coloured pixel");

   a_held_word_stays: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("held word vanished");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with an empty output register");

endmodule
